>>> sv/assert_macros.svh
// Assertion macros used by simple_point_test_3d.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/spt3d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spt3d_pkg;

  localparam int VOXELS           = 27;
  localparam int CENTRE           = 13;
  localparam int ROUNDS           = 26;
  localparam int ROUNDS_PER_STAGE = 4;
  localparam int PROP_STAGES      = (ROUNDS + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

  localparam int KIND_26 = 26;
  localparam int KIND_18 = 18;
  localparam int KIND_6  = 6;

  typedef logic [VOXELS-1:0] vox_t;

  function automatic vox_t nbr_mask(int x, int y, int z, int kind);
    vox_t m;
    int   nx;
    int   ny;
    int   nz;
    int   hops;
    m = '0;
    for (int dz = -1; dz <= 1; dz++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          nx   = x + dx;
          ny   = y + dy;
          nz   = z + dz;
          hops = int'(dx != 0) + int'(dy != 0) + int'(dz != 0);
          if (hops != 0 && nx >= 0 && nx <= 2 && ny >= 0 && ny <= 2 &&
              nz >= 0 && nz <= 2 && (kind != KIND_6 || hops == 1) &&
              (kind != KIND_18 || hops <= 2)) begin
            m[5'(nx + 3 * ny + 9 * nz)] = 1'b1;
          end
        end
      end
    end
    return m;
  endfunction

  function automatic vox_t grow(vox_t reach, vox_t visit, int kind);
    vox_t g;
    g = reach;
    for (int z = 0; z < 3; z++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          if (reach[5'(x + 3 * y + 9 * z)]) begin
            g = g | (nbr_mask(x, y, z, kind) & visit);
          end
        end
      end
    end
    return g;
  endfunction

  function automatic vox_t propagate(vox_t reach, vox_t visit, int kind);
    vox_t r;
    r = reach;
    for (int i = 0; i < ROUNDS_PER_STAGE; i++) begin
      r = grow(r, visit, kind);
    end
    return r;
  endfunction

  localparam vox_t CENTRE_MASK = vox_t'(1) << CENTRE;
  localparam vox_t FACE_MASK   = nbr_mask(1, 1, 1, KIND_6);
  localparam vox_t RING18_MASK = nbr_mask(1, 1, 1, KIND_18);

endpackage

`default_nettype wire

>>> sv/simple_point_test_3d.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple-point test for one 3x3x3 neighbourhood per transaction (26/6 connectivity).
// A transaction is taken whenever start is high and busy is low; busy is high only during
// reset and in the cycle after it, so one neighbourhood can enter every clock. The result
// shows on simple_flag with done high for exactly one cycle, after passing through one
// input stage loaded at the accepting edge, seven propagation stages of four growth
// rounds each, and one output stage. Results leave in input order and cannot be held
// off by the receiver.

`include "assert_macros.svh"

module simple_point_test_3d (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire spt3d_pkg::vox_t       neighbourhood,
  output logic                       done,
  output logic                       simple_flag
);
  import spt3d_pkg::*;

  localparam int LAST = PROP_STAGES;

  logic vld      [LAST+1];
  logic fg_any   [LAST+1];
  logic bg_any   [LAST+1];
  vox_t fg_vis   [LAST+1];
  vox_t fg_reach [LAST+1];
  vox_t bg_vis   [LAST+1];
  vox_t bg_conn  [LAST+1];
  vox_t bg_reach [LAST+1];

  logic accept;
  vox_t fg_in;
  vox_t bg_in;
  vox_t bg_face_in;

  assign accept     = start && !busy;
  assign fg_in      = neighbourhood & ~CENTRE_MASK;
  assign bg_in      = ~neighbourhood & ~CENTRE_MASK;
  assign bg_face_in = bg_in & FACE_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
    fg_any[0]   <= |fg_in;
    bg_any[0]   <= |bg_face_in;
    fg_vis[0]   <= fg_in;
    fg_reach[0] <= fg_in & (~fg_in + vox_t'(1));
    bg_vis[0]   <= bg_in & RING18_MASK;
    bg_conn[0]  <= bg_face_in;
    bg_reach[0] <= bg_face_in & (~bg_face_in + vox_t'(1));
  end

  for (genvar s = 1; s <= LAST; s++) begin : g_prop
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld[s-1];
      end
      fg_any[s]   <= fg_any[s-1];
      bg_any[s]   <= bg_any[s-1];
      fg_vis[s]   <= fg_vis[s-1];
      bg_vis[s]   <= bg_vis[s-1];
      bg_conn[s]  <= bg_conn[s-1];
      fg_reach[s] <= propagate(fg_reach[s-1], fg_vis[s-1], KIND_26);
      bg_reach[s] <= propagate(bg_reach[s-1], bg_vis[s-1], KIND_6);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAST];
    end
    simple_flag <= fg_any[LAST] && ((fg_vis[LAST] & ~fg_reach[LAST]) == '0) &&
                   bg_any[LAST] && ((bg_conn[LAST] & ~bg_reach[LAST]) == '0);
  end

  `ASSERT_NEXT(a_done_follows, clk, rst, vld[LAST], done)
  `ASSERT_NEXT(a_no_stray_done, clk, rst, !vld[LAST], !done)
  `ASSERT_IMPLIES(a_fg_seed_single, clk, rst, vld[0] && fg_any[0], $onehot(fg_reach[0]))

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import spt3d_pkg::vox_t;
  import spt3d_pkg::VOXELS;
  import spt3d_pkg::CENTRE;

  localparam int N_DIRECTED = 16;
  localparam int N_RANDOM   = 1650;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_TAIL = 12;
  localparam vox_t MID_BIT  = vox_t'(1) << CENTRE;

  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_SPARSE,
    SHAPE_DENSE,
    SHAPE_BLOB,
    SHAPE_HOLLOW
  } shape_e;

  typedef struct {
    bit answer;
    bit pinned;
    vox_t vox;
  } verdict_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  vox_t neighbourhood;
  logic done;
  logic simple_flag;
  logic pin_valid;
  logic pin_value;

  vox_t touch26 [VOXELS];
  vox_t touch6 [VOXELS];
  vox_t face_set;
  vox_t shell18;

  verdict_t verdict_q[$];
  int n_sent;
  int n_checked;
  int n_simple;
  int n_errors;
  int idle_cycles;

  vox_t dir_vox [N_DIRECTED] = '{
    27'h0000000, 27'h0002000, 27'h7FFFFFF, 27'h7FFDFFF,
    27'h0000001, 27'h0000010, 27'h4000001, 27'h7BFFFFF,
    27'h7BFFFEF, 27'h0002001, 27'h7FC0000, 27'h7FC01FF,
    27'h003DE00, 27'h5555555, 27'h2AAAAAA, 27'h0410410
  };
  int dir_ans [N_DIRECTED] = '{
    0, 0, 0, 0,
    1, 1, 0, 1,
    0, 1, 1, 0,
    0, -1, -1, -1
  };

  simple_point_test_3d u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .neighbourhood (neighbourhood),
    .done          (done),
    .simple_flag   (simple_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int iabs(int a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic bit linked(vox_t members, vox_t path, bit face_only);
    vox_t reach;
    vox_t grown;
    if (members == '0) return 1'b0;
    reach = members & (~members + vox_t'(1));
    forever begin
      grown = reach;
      for (int k = 0; k < VOXELS; k++) begin
        if (reach[5'(k)])
          grown = grown | ((face_only ? touch6[5'(k)] : touch26[5'(k)]) & path);
      end
      if (grown == reach) break;
      reach = grown;
    end
    return (members & ~reach) == '0;
  endfunction

  function automatic bit simple_point_of(vox_t v);
    vox_t fg;
    vox_t bg;
    fg = v & ~MID_BIT;
    bg = ~v & ~MID_BIT;
    return linked(fg, fg, 1'b0) && linked(bg & face_set, bg & shell18, 1'b1);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic vox_t grow_blob(int steps);
    vox_t v;
    int cur;
    int nxt;
    cur = $urandom_range(0, VOXELS - 1);
    if (cur == CENTRE) cur = 0;
    v = vox_t'(1) << cur;
    repeat (steps) begin
      do nxt = $urandom_range(0, VOXELS - 1);
      while (!touch26[5'(cur)][5'(nxt)] || nxt == CENTRE);
      v[5'(nxt)] = 1'b1;
      cur = nxt;
    end
    return v;
  endfunction

  function automatic vox_t random_vox();
    vox_t v;
    shape_e shape;
    shape = shape_e'($urandom_range(0, 4));
    v = '0;
    case (shape)
      SHAPE_UNIFORM: v = vox_t'($urandom);
      SHAPE_SPARSE: begin
        repeat ($urandom_range(1, 5)) v[5'($urandom_range(0, VOXELS - 1))] = 1'b1;
      end
      SHAPE_DENSE: begin
        v = '1;
        repeat ($urandom_range(1, 5)) v[5'($urandom_range(0, VOXELS - 1))] = 1'b0;
      end
      SHAPE_BLOB: v = grow_blob($urandom_range(0, 14));
      SHAPE_HOLLOW: v = ~grow_blob($urandom_range(0, 14));
      default: v = '0;
    endcase
    v[CENTRE] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  task automatic send(input vox_t v, input int pinned_answer);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    neighbourhood <= v;
    pin_valid     <= (pinned_answer >= 0);
    pin_value     <= (pinned_answer > 0);
    do @(posedge clk);
    while (busy);
    n_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk);
    while (verdict_q.size() != 0);
  endtask

  // Record accepted transactions and score results on the same edge.
  always @(posedge clk) begin
    verdict_t exp_v;
    verdict_t got_v;
    if (!rst) begin
      if (done) begin
        if (verdict_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result simple_flag=%0b", simple_flag);
        end else begin
          exp_v = verdict_q.pop_front();
          n_checked++;
          if (simple_flag) n_simple++;
          if (simple_flag !== exp_v.answer) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch vox=%07h expected simple_flag=%0b actual=%b",
                       exp_v.vox, exp_v.answer, simple_flag);
          end
        end
      end
      if (start && !busy) begin
        got_v.vox    = neighbourhood;
        got_v.pinned = pin_valid;
        got_v.answer = pin_valid ? pin_value : simple_point_of(neighbourhood);
        verdict_q.push_back(got_v);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no activity for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int ka;
    int kb;
    int cheb;
    int manh;
    rst           <= 1'b1;
    start         <= 1'b0;
    neighbourhood <= '0;
    pin_valid     <= 1'b0;
    pin_value     <= 1'b0;
    n_sent        = 0;
    n_checked     = 0;
    n_simple      = 0;
    n_errors      = 0;
    idle_cycles   = 0;
    face_set      = '0;
    shell18       = '0;
    for (ka = 0; ka < VOXELS; ka++) begin
      touch26[5'(ka)] = '0;
      touch6[5'(ka)]  = '0;
      for (kb = 0; kb < VOXELS; kb++) begin
        cheb = 0;
        manh = iabs(ka % 3 - kb % 3) + iabs((ka / 3) % 3 - (kb / 3) % 3) +
               iabs(ka / 9 - kb / 9);
        if (iabs(ka % 3 - kb % 3) > cheb) cheb = iabs(ka % 3 - kb % 3);
        if (iabs((ka / 3) % 3 - (kb / 3) % 3) > cheb) cheb = iabs((ka / 3) % 3 - (kb / 3) % 3);
        if (iabs(ka / 9 - kb / 9) > cheb) cheb = iabs(ka / 9 - kb / 9);
        if (cheb == 1) touch26[5'(ka)][5'(kb)] = 1'b1;
        if (manh == 1) touch6[5'(ka)][5'(kb)] = 1'b1;
        if (ka == CENTRE && cheb == 1 && manh <= 2) shell18[5'(kb)] = 1'b1;
        if (ka == CENTRE && manh == 1) face_set[5'(kb)] = 1'b1;
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) send(dir_vox[i], dir_ans[i]);
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      send(random_vox(), -1);
      if (i % 500 == 499) drain();
    end
    drain();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Ran %0d neighbourhoods (%0d directed, rest blobs, hollows, sparse, dense, uniform).",
             n_sent, N_DIRECTED);
    $display("Scored %0d results: %0d simple, %0d not simple.",
             n_checked, n_simple, n_checked - n_simple);
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/spt3d_pkg.sv
sv/simple_point_test_3d.sv
bench/tb_top.sv
